FILE: rtl/core/stc_pkg.sv
// shared widths, codes and beat types for the clamped step-toward-target block
`timescale 1ns / 1ps

package stc_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int STEP_BITS  = 20;

    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int SUMSQ_BITS = 2 * MAG_BITS;
    localparam int MUL_BITS   = (MAG_BITS > STEP_BITS) ? MAG_BITS : STEP_BITS;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    localparam int REM_BITS   = MAG_BITS + 3;
    localparam int ITER_BITS  = $clog2(MAG_BITS);

    localparam logic [STEP_BITS-1:0] MAX_STEP_RST = STEP_BITS'(1) << FRAC_BITS;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MOVE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                      opcode;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] new_x;
        logic signed [COORD_BITS-1:0] new_y;
        logic                         arrived;
    } t_out_beat;

    typedef struct packed {
        logic [MUL_BITS-1:0] mul_a;
        logic [MUL_BITS-1:0] mul_b;
        logic [REM_BITS-1:0] sub_a;
        logic [REM_BITS-1:0] sub_b;
    } t_unit_op;

    typedef struct packed {
        logic [PROD_BITS-1:0] prod;
        logic [REM_BITS-1:0]  diff;
        logic                 ge;
    } t_unit_res;

endpackage

FILE: rtl/core/stc_unit.sv
// shared arithmetic unit: registered multiplier and trial subtractor
`timescale 1ns / 1ps

module stc_unit
    import stc_pkg::*;
(
    input  logic      i_clk,
    input  t_unit_op  i_op,
    output t_unit_res o_res
);

    logic [PROD_BITS-1:0] r_prod;
    logic [REM_BITS:0]    w_diff;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.mul_a * i_op.mul_b;
    end

    assign w_diff = {1'b0, i_op.sub_a} - {1'b0, i_op.sub_b};

    assign o_res.prod = r_prod;
    assign o_res.diff = w_diff[REM_BITS-1:0];
    assign o_res.ge   = ~w_diff[REM_BITS];

endmodule

FILE: rtl/core/step_toward_target_clamped.sv
// top level: position register, sequencer for length, clamp and scaled move
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_in_beat  (t_in_beat)
// out       output     o_out_valid / i_out_stall o_out_beat (t_out_beat)
// cfg       input      i_cfg_we                  i_cfg_wdata (max step)
//
// a load beat passes DIFF and DONE; a move that snaps to the target ends after TEST;
// a scaled move runs the bit-serial square root and the two bit-serial divides
// through the shared unit before APPLY and DONE
// o_in_stall is high from acceptance until the result moves to the output register
// a waiting result does not block the next input beat; reset is synchronous and
// clears position to zero and max step to one

module step_toward_target_clamped
    import stc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_we,
    input  logic [STEP_BITS-1:0] i_cfg_wdata
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DIFF  = 15'b000000000000010,
        S_SQX   = 15'b000000000000100,
        S_SQY   = 15'b000000000001000,
        S_SQS   = 15'b000000000010000,
        S_TEST  = 15'b000000000100000,
        S_SQRT  = 15'b000000001000000,
        S_MULX  = 15'b000000010000000,
        S_LDX   = 15'b000000100000000,
        S_DIVX  = 15'b000001000000000,
        S_MULY  = 15'b000010000000000,
        S_LDY   = 15'b000100000000000,
        S_DIVY  = 15'b001000000000000,
        S_APPLY = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    t_state                r_state, n_state;
    logic [ITER_BITS-1:0]  r_cnt;
    logic [STEP_BITS-1:0]  r_max_step;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_out_valid;
    t_out_beat             r_out_beat;

    t_opcode               r_op;
    logic [COORD_BITS-1:0] r_tx, r_ty;
    logic [COORD_BITS-1:0] r_nx, r_ny;
    logic [MAG_BITS-1:0]   r_ax, r_ay;
    logic                  r_sx, r_sy;
    logic [SUMSQ_BITS-1:0] r_sumsq;
    logic [SUMSQ_BITS-1:0] r_rad;
    logic [REM_BITS-1:0]   r_rem;
    logic [MAG_BITS-1:0]   r_root;
    logic [MAG_BITS-1:0]   r_num;
    logic [MAG_BITS-1:0]   r_qx, r_qy;

    logic [MAG_BITS-1:0]     w_dx, w_dy;
    logic                    w_last;
    logic                    w_snap;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic signed [COORD_BITS+1:0] w_sum_x, w_sum_y;
    t_unit_op                w_op;
    t_unit_res               w_res;

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [COORD_BITS+1:0] v);
        logic [COORD_BITS-1:0] res;
        if (v[COORD_BITS+1] == v[COORD_BITS] && v[COORD_BITS] == v[COORD_BITS-1]) begin
            res = v[COORD_BITS-1:0];
        end else if (v[COORD_BITS+1]) begin
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign w_dx = $signed({r_tx[COORD_BITS-1], r_tx}) - $signed({r_px[COORD_BITS-1], r_px});
    assign w_dy = $signed({r_ty[COORD_BITS-1], r_ty}) - $signed({r_py[COORD_BITS-1], r_py});

    assign w_last = (r_cnt == ITER_BITS'(MAG_BITS - 1));
    assign w_snap = (PROD_BITS'(r_sumsq) <= w_res.prod);

    assign w_sum_x = r_sx ? $signed({{2{r_px[COORD_BITS-1]}}, r_px}) - $signed({1'b0, r_qx})
                          : $signed({{2{r_px[COORD_BITS-1]}}, r_px}) + $signed({1'b0, r_qx});
    assign w_sum_y = r_sy ? $signed({{2{r_py[COORD_BITS-1]}}, r_py}) - $signed({1'b0, r_qy})
                          : $signed({{2{r_py[COORD_BITS-1]}}, r_py}) + $signed({1'b0, r_qy});

    // operand steering for the shared unit
    always_comb begin
        w_op = '0;
        unique case (r_state) inside
            S_SQX: begin
                w_op.mul_a = MUL_BITS'(r_ax);
                w_op.mul_b = MUL_BITS'(r_ax);
            end
            S_SQY: begin
                w_op.mul_a = MUL_BITS'(r_ay);
                w_op.mul_b = MUL_BITS'(r_ay);
            end
            S_SQS: begin
                w_op.mul_a = MUL_BITS'(r_max_step);
                w_op.mul_b = MUL_BITS'(r_max_step);
            end
            S_MULX: begin
                w_op.mul_a = MUL_BITS'(r_ax);
                w_op.mul_b = MUL_BITS'(r_max_step);
            end
            S_MULY: begin
                w_op.mul_a = MUL_BITS'(r_ay);
                w_op.mul_b = MUL_BITS'(r_max_step);
            end
            S_SQRT: begin
                w_op.sub_a = {r_rem[REM_BITS-3:0], r_rad[SUMSQ_BITS-1 -: 2]};
                w_op.sub_b = REM_BITS'({r_root, 2'b01});
            end
            S_DIVX, S_DIVY: begin
                w_op.sub_a = {r_rem[REM_BITS-2:0], r_num[MAG_BITS-1]};
                w_op.sub_b = REM_BITS'(r_root);
            end
            default: begin
            end
        endcase
    end

    stc_unit u_unit (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_res (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_DIFF;
            S_DIFF:  n_state = (r_op == OP_LOAD) ? S_DONE : S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQS;
            S_SQS:   n_state = S_TEST;
            S_TEST:  n_state = w_snap ? S_DONE : S_SQRT;
            S_SQRT:  if (w_last) n_state = S_MULX;
            S_MULX:  n_state = S_LDX;
            S_LDX:   n_state = S_DIVX;
            S_DIVX:  if (w_last) n_state = S_MULY;
            S_MULY:  n_state = S_LDY;
            S_LDY:   n_state = S_DIVY;
            S_DIVY:  if (w_last) n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_max_step  <= MAX_STEP_RST;
            r_px        <= '0;
            r_py        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_step <= i_cfg_wdata;
            end
            if (r_state == S_SQRT || r_state == S_DIVX || r_state == S_DIVY) begin
                r_cnt <= w_last ? '0 : r_cnt + ITER_BITS'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_px        <= r_nx;
                r_py        <= r_ny;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= i_in_beat.opcode;
            r_tx <= i_in_beat.target_x;
            r_ty <= i_in_beat.target_y;
        end
        unique case (r_state) inside
            S_DIFF: begin
                r_sx <= w_dx[MAG_BITS-1];
                r_sy <= w_dy[MAG_BITS-1];
                r_ax <= w_dx[MAG_BITS-1] ? MAG_BITS'(0) - w_dx : w_dx;
                r_ay <= w_dy[MAG_BITS-1] ? MAG_BITS'(0) - w_dy : w_dy;
                r_nx <= r_tx;
                r_ny <= r_ty;
            end
            S_SQS: begin
                r_sumsq <= r_sumsq + w_res.prod[SUMSQ_BITS-1:0];
            end
            S_SQRT: begin
                r_rad <= r_rad << 2;
                if (w_res.ge) begin
                    r_rem  <= w_res.diff;
                    r_root <= {r_root[MAG_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= w_op.sub_a;
                    r_root <= {r_root[MAG_BITS-2:0], 1'b0};
                end
            end
            S_LDX, S_LDY: begin
                r_rem <= REM_BITS'(w_res.prod[MAG_BITS+STEP_BITS-1:MAG_BITS]);
                r_num <= w_res.prod[MAG_BITS-1:0];
            end
            S_DIVX, S_DIVY: begin
                r_rem <= w_res.ge ? w_res.diff : w_op.sub_a;
                r_num <= {r_num[MAG_BITS-2:0], w_res.ge};
                if (w_last && r_state == S_DIVX) begin
                    r_qx <= {r_num[MAG_BITS-2:0], w_res.ge};
                end
                if (w_last && r_state == S_DIVY) begin
                    r_qy <= {r_num[MAG_BITS-2:0], w_res.ge};
                end
            end
            S_APPLY: begin
                r_nx <= sat(w_sum_x);
                r_ny <= sat(w_sum_y);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_beat.new_x   <= r_nx;
                    r_out_beat.new_y   <= r_ny;
                    r_out_beat.arrived <= (r_nx == r_tx) && (r_ny == r_ty);
                end
            end
            default: begin
            end
        endcase
        // sum of squares terms arrive in the cycle after their multiply
        if (r_state == S_SQY) begin
            r_sumsq <= w_res.prod[SUMSQ_BITS-1:0];
        end
        if (r_state == S_TEST && !w_snap) begin
            r_rad  <= r_sumsq;
            r_rem  <= '0;
            r_root <= '0;
        end
    end

    // order of sum of squares capture: ax^2 in SQY, ay^2 added in SQS, compare in TEST
    // (SQS arm above adds rather than overwrites once SQY has captured ax^2)

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input accepted while busy was not flagged");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the finish state");

    a_len_ge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULX) |-> (MUL_BITS'(r_max_step) <= MUL_BITS'(r_root)))
        else $error("length below max step on the scaled path");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (r_qx <= r_ax && r_qy <= r_ay))
        else $error("scaled move exceeds the distance to target");

endmodule

FILE: tb/tb.sv
// testbench for step_toward_target_clamped: directed table, then random phases with idling
`timescale 1ns / 1ps

module tb;
    import stc_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     DRAIN_CYCLES   = 100;
    localparam int     PHASES         = 8;
    localparam int     PHASE_BEATS    = 66;
    localparam int     PRINT_CAP      = 40;
    localparam longint COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
    localparam longint COORD_MIN      = -(2 ** (COORD_BITS - 1));
    localparam int     STEP_TOP       = 2 ** STEP_BITS - 1;

    typedef enum logic [1:0] {
        ROW_FREE,
        ROW_FIXED,
        ROW_STEP
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_opcode   op;
        int        x;
        int        y;
        int        ex;
        int        ey;
        logic      ea;
    } t_row;

    localparam int DIR_N = 23;

    t_row dir_rows [DIR_N] = '{
        '{ROW_FIXED, OP_MOVE,        0,        0,        0,        0, 1'b1},
        '{ROW_FIXED, OP_LOAD,  8388607, -8388608,  8388607, -8388608, 1'b1},
        '{ROW_FREE,  OP_MOVE, -8388608,  8388607,        0,        0, 1'b0},
        '{ROW_FIXED, OP_LOAD,        0,        0,        0,        0, 1'b1},
        '{ROW_FIXED, OP_MOVE,      300,        0,      256,        0, 1'b0},
        '{ROW_FIXED, OP_LOAD,        0,        0,        0,        0, 1'b1},
        '{ROW_FIXED, OP_MOVE,      256,        1,      256,        1, 1'b1},
        '{ROW_FIXED, OP_LOAD,        0,        0,        0,        0, 1'b1},
        '{ROW_FIXED, OP_MOVE,        0,     -256,        0,     -256, 1'b1},
        '{ROW_FREE,  OP_MOVE,     1000,     1000,        0,        0, 1'b0},
        '{ROW_FREE,  OP_MOVE,       -3,        7,        0,        0, 1'b0},
        '{ROW_STEP,  OP_LOAD,        0,        0,        0,        0, 1'b0},
        '{ROW_FIXED, OP_LOAD,       10,       20,       10,       20, 1'b1},
        '{ROW_FIXED, OP_MOVE,     5000,    -7000,       10,       20, 1'b0},
        '{ROW_FIXED, OP_MOVE,       10,       20,       10,       20, 1'b1},
        '{ROW_STEP,  OP_LOAD, STEP_TOP,        0,        0,        0, 1'b0},
        '{ROW_FIXED, OP_LOAD, -8388608, -8388608, -8388608, -8388608, 1'b1},
        '{ROW_FREE,  OP_MOVE,  8388607,  8388607,        0,        0, 1'b0},
        '{ROW_FREE,  OP_MOVE,  8388607,  8388607,        0,        0, 1'b0},
        '{ROW_FREE,  OP_MOVE, -8388608,  8388607,        0,        0, 1'b0},
        '{ROW_STEP,  OP_LOAD,        1,        0,        0,        0, 1'b0},
        '{ROW_FIXED, OP_LOAD,        0,        0,        0,        0, 1'b1},
        '{ROW_FREE,  OP_MOVE,        2,        3,        0,        0, 1'b0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_beat             i_in_beat   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [STEP_BITS-1:0] i_cfg_wdata = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_beat            o_out_beat;

    longint               pos_x          = 0;
    longint               pos_y          = 0;
    logic [STEP_BITS-1:0] step_cfg       = MAX_STEP_RST;
    t_out_beat            position_due_q [$];
    int                   mismatch_cnt   = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_req       = 0;

    step_toward_target_clamped u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint axis_move(longint d, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? -d : d;
        q   = (mag * step_cfg) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // advances the tracked position by one beat and returns the result it produces
    function automatic t_out_beat next_position(t_in_beat b);
        longint          tx, ty, dx, dy, nx, ny;
        longint unsigned ax, ay, sumsq, lim, len, c;
        t_out_beat       r;
        tx = $signed(b.target_x);
        ty = $signed(b.target_y);
        nx = tx;
        ny = ty;
        if (b.opcode == OP_MOVE) begin
            dx    = tx - pos_x;
            dy    = ty - pos_y;
            ax    = (dx < 0) ? -dx : dx;
            ay    = (dy < 0) ? -dy : dy;
            sumsq = ax * ax + ay * ay;
            lim   = longint'(step_cfg) * longint'(step_cfg);
            if (sumsq > lim) begin
                len = 0;
                for (int k = 31; k >= 0; k--) begin
                    c = len | (64'd1 << k);
                    if (c * c <= sumsq) len = c;
                end
                nx = clamp_coord(pos_x + axis_move(dx, len));
                ny = clamp_coord(pos_y + axis_move(dy, len));
            end
        end
        pos_x     = nx;
        pos_y     = ny;
        r.new_x   = COORD_BITS'(nx);
        r.new_y   = COORD_BITS'(ny);
        r.arrived = (nx == tx) && (ny == ty);
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0: return COORD_BITS'(COORD_MAX);
            1: return COORD_BITS'(COORD_MIN);
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // mostly targets near the position so that snaps and short moves both occur
    function automatic t_in_beat random_beat();
        t_in_beat b;
        longint   span;
        int       pick;
        span     = longint'(step_cfg) * 3 + 8;
        pick     = $urandom_range(0, 9);
        b.opcode = roll(20) ? OP_LOAD : OP_MOVE;
        if (pick < 3) begin
            b.target_x = COORD_BITS'($urandom());
            b.target_y = COORD_BITS'($urandom());
        end else if (pick < 8) begin
            b.target_x = COORD_BITS'(clamp_coord(
                pos_x + longint'($urandom_range(0, int'(2 * span))) - span));
            b.target_y = COORD_BITS'(clamp_coord(
                pos_y + longint'($urandom_range(0, int'(2 * span))) - span));
        end else if (pick == 8) begin
            b.target_x = COORD_BITS'(pos_x);
            b.target_y = COORD_BITS'(pos_y);
        end else begin
            b.target_x = corner_coord();
            b.target_y = corner_coord();
        end
        return b;
    endfunction

    function automatic logic [STEP_BITS-1:0] phase_step(int p);
        case (p)
            0: return MAX_STEP_RST;
            1: return '0;
            2: return '1;
            3: return STEP_BITS'(1);
            4: return STEP_BITS'($urandom_range(2, 2048));
            5: return STEP_BITS'($urandom_range(0, STEP_TOP));
            6: return '1;
            default: return STEP_BITS'($urandom_range(256, 65535));
        endcase
    endfunction

    task automatic flag_error(input string what, input longint got, input longint want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic offer_beat(input t_in_beat b, input bit fixed, input t_out_beat want);
        t_out_beat due;
        while (roll(send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        due = next_position(b);
        position_due_q.push_back(fixed ? want : due);
    endtask

    // only written with the block drained
    task automatic write_step(input logic [STEP_BITS-1:0] v);
        i_in_valid <= 1'b0;
        while (position_due_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        step_cfg     = v;
    endtask

    initial begin : out_side
        t_out_beat want;
        int        hold_left;
        int        hold_ack;
        hold_left = 0;
        hold_ack  = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (position_due_q.size() == 0) begin
                    flag_error("beat with none due", 1, 0);
                end else begin
                    want = position_due_q.pop_front();
                    if (o_out_beat.new_x !== want.new_x)
                        flag_error("new_x", $signed(o_out_beat.new_x), $signed(want.new_x));
                    if (o_out_beat.new_y !== want.new_y)
                        flag_error("new_y", $signed(o_out_beat.new_y), $signed(want.new_y));
                    if (o_out_beat.arrived !== want.arrived)
                        flag_error("arrived", o_out_beat.arrived, want.arrived);
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= roll(recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_row      row;
        t_in_beat  b;
        t_out_beat want;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_STEP) begin
                write_step(STEP_BITS'(row.x));
            end else begin
                b.opcode     = row.op;
                b.target_x   = COORD_BITS'(row.x);
                b.target_y   = COORD_BITS'(row.y);
                want.new_x   = COORD_BITS'(row.ex);
                want.new_y   = COORD_BITS'(row.ey);
                want.arrived = row.ea;
                offer_beat(b, row.kind == ROW_FIXED, want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_step(phase_step(p));
            send_idle_pct  = (p % 4 == 1) ? 87 : (p % 4 == 3) ? 12 : 0;
            recv_stall_pct = (p % 4 == 2) ? 87 : (p % 4 == 3) ? 12 : 0;
            // long output hold while beats keep coming
            if (p == 4) hold_req++;
            for (int n = 0; n < PHASE_BEATS; n++)
                offer_beat(random_beat(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (position_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
